[sv/tdp_pkg.sv]
// Package for the trial-division primality tester.
// Holds the controller state type, the divider status struct and fixed constants.
// No dependencies.
package tdp_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    // Status that the serial divider hands back to the controller.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_status;

    // Small constants of the 6k-1 / 6k+1 scheme.
    localparam int unsigned C_TWO   = 2;
    localparam int unsigned C_THREE = 3;
    localparam int unsigned C_FIRST = 5;
    localparam int unsigned C_STEP  = 6;

endpackage

[sv/tdp_serdiv.sv]
// Bit-serial restoring remainder unit for the primality tester.
// Shifts the dividend in one bit per cycle, MSB first; depends on tdp_pkg.
module tdp_serdiv
    import tdp_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_status   o_status
);

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic [NW-1:0] r_shift;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_zero;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic [DW-1:0] n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_shift[NW-1]};
        w_diff  = w_trial - {1'b0, r_d};
        if (w_trial >= {1'b0, r_d}) begin
            n_rem = w_diff[DW-1:0];
        end else begin
            n_rem = w_trial[DW-1:0];
        end
    end

    // Control: busy flag, step counter and a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shift register, divisor and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_shift <= i_dividend;
            r_d     <= i_divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << 1;
            r_rem   <= n_rem;
            if (r_cnt == '0) begin
                r_zero <= (n_rem == '0);
            end
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = r_zero;

endmodule

[sv/trial_division_primality_test.sv]
// Numbers below 4 and even numbers are answered without division, with the result strobe
// in the cycle after acceptance. Other numbers are first divided by three, then by each
// candidate pair 6k-1, 6k+1 while the square of 6k-1 does not exceed the number; every
// trial remainder comes from the bit-serial divider.
// One transaction at a time; the receiver cannot stall; synchronous active-low reset idles.
module trial_division_primality_test
    import tdp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_number,
    output logic        o_busy,
    output logic        o_valid,
    output logic        o_is_prime
);

    localparam int NW = NUMBER_WIDTH;
    localparam int DW = (NW + 1) / 2 + 2;
    localparam int SW = NW + 2;

    t_state        r_state;
    t_state        n_state;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_div;
    logic [SW-1:0] r_sq;
    logic          r_three;
    logic          r_upper;
    logic          r_prime;

    logic [NW-1:0] w_num;
    logic          w_accept;
    logic          w_div_start;
    logic [DW-1:0] w_divisor;
    logic          w_finish;
    logic          w_fin_prime;
    logic          w_set_first;
    logic          w_set_upper;
    logic          w_advance;
    t_div_status   w_stat;

    // Input number, cut or zero-extended to the working width.
    generate
        if (NW <= 32) begin : g_narrow
            assign w_num = i_number[NW-1:0];
        end else begin : g_wide
            assign w_num = {{(NW - 32){1'b0}}, i_number};
        end
    endgenerate

    assign w_accept = i_start && (r_state == ST_IDLE);

    // Remainder unit shared by every trial division.
    tdp_serdiv #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num),
        .i_divisor  (w_divisor),
        .o_status   (w_stat)
    );

    // Controller outputs: divider starts and datapath updates.
    always_comb begin
        w_div_start = 1'b0;
        w_divisor   = r_div;
        w_finish    = 1'b0;
        w_fin_prime = 1'b0;
        w_set_first = 1'b0;
        w_set_upper = 1'b0;
        w_advance   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_num < NW'(C_FIRST - 1)) begin
                        w_finish    = 1'b1;
                        w_fin_prime = (w_num >= NW'(C_TWO));
                    end else if (!w_num[0]) begin
                        w_finish = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (r_sq > {2'b00, r_num}) begin
                    w_finish    = 1'b1;
                    w_fin_prime = 1'b1;
                end else begin
                    w_div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    if (w_stat.rem_zero) begin
                        w_finish = 1'b1;
                    end else if (r_three) begin
                        w_set_first = 1'b1;
                    end else if (!r_upper) begin
                        w_div_start = 1'b1;
                        w_divisor   = r_div + DW'(C_TWO);
                        w_set_upper = 1'b1;
                    end else begin
                        w_advance = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Controller next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_finish ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_finish ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (w_finish) begin
                    n_state = ST_DONE;
                end else if (w_set_first || w_advance) begin
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Candidate divisor, its square and the held number. On a new transaction
    // the first check divides by three, so the divisor starts at three and its
    // square is forced to zero so the bound test always passes.
    // Moving to the next pair adds (d+6)^2 - d^2 = 12d + 36, with 12d built as 8d + 4d.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num   <= w_num;
            r_div   <= DW'(C_THREE);
            r_sq    <= '0;
            r_three <= 1'b1;
            r_upper <= 1'b0;
        end
        if (w_set_first) begin
            r_div   <= DW'(C_FIRST);
            r_sq    <= SW'(C_FIRST * C_FIRST);
            r_three <= 1'b0;
            r_upper <= 1'b0;
        end
        if (w_set_upper) begin
            r_upper <= 1'b1;
        end
        if (w_advance) begin
            r_div   <= r_div + DW'(C_STEP);
            r_sq    <= r_sq + SW'({r_div, 3'b000}) + SW'({r_div, 2'b00})
                       + SW'(C_STEP * C_STEP);
            r_upper <= 1'b0;
        end
        if (w_finish) begin
            r_prime <= w_fin_prime;
        end
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_valid    = (r_state == ST_DONE);
    assign o_is_prime = r_prime;

endmodule

[sv/tdp_checker.sv]
// Port-level checker for the trial-division primality tester.
// Bound to trial_division_primality_test; uses no package items.
module tdp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after an accepted transaction");

    // A result appears only while a transaction is in progress.
    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while idle");

    // After the result the block is idle again and the strobe is a single pulse.
    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_busy && !o_valid))
        else $error("block did not return to idle after a result");

    // Reset leaves the block idle with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_valid))
        else $error("block not idle after reset");

endmodule

bind trial_division_primality_test tdp_checker u_tdp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
